### sv/srs_pkg.sv
`timescale 1ns / 1ps

package srs_pkg;

    localparam int SLOT_W       = 3;
    localparam int MAX_WINDOW   = 1 << SLOT_W;
    localparam int RESULT_LIMIT = 8;
    localparam int EFF_MAX      = (MAX_WINDOW < RESULT_LIMIT) ? MAX_WINDOW : RESULT_LIMIT;
    localparam int CNT_W        = $clog2(EFF_MAX + 1);

    localparam int FRAME_W  = 16;
    localparam int WIN_W    = 4;
    localparam int TMR_W    = 4;
    localparam int MASK_W   = 8;
    localparam int ATT_W    = $clog2(MASK_W);
    localparam int ACT_W    = 2;
    localparam int EV_W     = 3;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_TX   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    localparam logic [EV_W-1:0] EV_SENT        = 3'd0;
    localparam logic [EV_W-1:0] EV_LOST        = 3'd1;
    localparam logic [EV_W-1:0] EV_ACK_OK      = 3'd2;
    localparam logic [EV_W-1:0] EV_ACK_IGNORED = 3'd3;
    localparam logic [EV_W-1:0] EV_TIMEOUT     = 3'd4;
    localparam logic [EV_W-1:0] EV_NONE        = 3'd5;

    localparam logic [CFG_IX_W-1:0] CFG_WIN_LEN       = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_FRAME_COUNT   = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [WIN_W-1:0]   RST_WIN_LEN       = 4'd4;
    localparam logic [FRAME_W-1:0] RST_FRAME_COUNT   = 16'd16;
    localparam logic [TMR_W-1:0]   RST_TIMEOUT_TICKS = 4'd3;

    typedef struct packed {
        logic [WIN_W-1:0]   win_len;
        logic [FRAME_W-1:0] frame_count;
        logic [TMR_W-1:0]   timeout_ticks;
    } cfg_t;

    typedef enum logic [2:0] {
        SOP_NONE  = 3'd0,
        SOP_SEND  = 3'd1,
        SOP_ACK   = 3'd2,
        SOP_CLEAR = 3'd3,
        SOP_TICK  = 3'd4
    } slot_op_t;

    typedef struct packed {
        slot_op_t          op;
        logic [SLOT_W-1:0] slot;
        logic [TMR_W-1:0]  timer;
    } slot_cmd_t;

    typedef struct packed {
        logic [EV_W-1:0]    ev;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] base;
        logic               last;
    } result_t;

endpackage

### sv/selective_repeat_sender_unit.sv
`timescale 1ns / 1ps

// Selective-repeat ARQ sender. Each input transaction carries one action in s_tuser:
// transmit pass, acknowledgement (frame in s_tdata) or timer tick; each produces one
// result transaction per frame sent, lost or timed out, one for an acknowledgement,
// or a single none result, the final one flagged with m_tlast. A transmit pass or tick
// visits the window one slot per cycle while no held result stalls it, through a
// shared adder/comparator sequencer: accept, one visit per slot, end check, final result.
// An acknowledgement is accepted and checked; an accepted one then clears each frame
// the window base slides past (at most 8) before its final result. Backpressure on
// m_tready can hold the scan and the final result. A finished result sits in the
// output register while the next transaction is accepted. Configuration is to be written
// through cfg_we/cfg_index/cfg_wdata only while the block is idle, which it does not enforce.
module selective_repeat_sender_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srs_pkg::S_DATA_W-1:0]    s_tdata,   // ack_frame, loss_mask
    input  logic [srs_pkg::ACT_W-1:0]       s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srs_pkg::M_DATA_W-1:0]    m_tdata,   // frame_number, window_base
    output logic [srs_pkg::EV_W-1:0]        m_tuser,   // event_res
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [srs_pkg::CFG_IX_W-1:0]    cfg_index,
    input  logic [srs_pkg::CFG_D_W-1:0]     cfg_wdata
);
    import srs_pkg::*;

    cfg_t                          cfg_reg;
    slot_cmd_t                     cmd;
    logic [MAX_WINDOW-1:0]         sent_vec;
    logic [MAX_WINDOW-1:0]         acked_vec;
    logic [MAX_WINDOW-1:0][TMR_W-1:0] timer_vec;
    logic                          res_valid;
    logic                          res_ready;
    result_t                       res;
    logic                          m_valid_reg, m_valid_next;
    result_t                       m_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_len       <= RST_WIN_LEN;
            cfg_reg.frame_count   <= RST_FRAME_COUNT;
            cfg_reg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIN_LEN:       cfg_reg.win_len       <= cfg_wdata[WIN_W-1:0];
                CFG_FRAME_COUNT:   cfg_reg.frame_count   <= cfg_wdata[FRAME_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata[TMR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    srs_slots u_slots (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sent_vec  (sent_vec),
        .acked_vec (acked_vec),
        .timer_vec (timer_vec)
    );

    srs_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg_reg),
        .sent_vec  (sent_vec),
        .acked_vec (acked_vec),
        .timer_vec (timer_vec),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.base, m_res_reg.frame};
    assign m_tuser  = m_res_reg.ev;
    assign m_tlast  = m_res_reg.last;

endmodule

### sv/srs_slots.sv
`timescale 1ns / 1ps

module srs_slots (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  srs_pkg::slot_cmd_t                             cmd,
    output logic [srs_pkg::MAX_WINDOW-1:0]                 sent_vec,
    output logic [srs_pkg::MAX_WINDOW-1:0]                 acked_vec,
    output logic [srs_pkg::MAX_WINDOW-1:0][srs_pkg::TMR_W-1:0] timer_vec
);
    import srs_pkg::*;

    logic [MAX_WINDOW-1:0]             sent_reg,  sent_next;
    logic [MAX_WINDOW-1:0]             acked_reg, acked_next;
    logic [MAX_WINDOW-1:0][TMR_W-1:0]  timer_reg, timer_next;
    logic [TMR_W-1:0]                  dec_val;

    assign dec_val = (timer_reg[cmd.slot] != '0) ? timer_reg[cmd.slot] - TMR_W'(1) : '0;

    always_comb begin
        sent_next  = sent_reg;
        acked_next = acked_reg;
        timer_next = timer_reg;
        case (cmd.op)
            SOP_SEND: begin
                sent_next[cmd.slot]  = 1'b1;
                timer_next[cmd.slot] = cmd.timer;
            end
            SOP_ACK: begin
                acked_next[cmd.slot] = 1'b1;
                timer_next[cmd.slot] = '0;
            end
            SOP_CLEAR: begin
                sent_next[cmd.slot]  = 1'b0;
                acked_next[cmd.slot] = 1'b0;
                timer_next[cmd.slot] = '0;
            end
            SOP_TICK: begin
                timer_next[cmd.slot] = dec_val;
                if (dec_val == '0) begin
                    sent_next[cmd.slot] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg  <= '0;
            acked_reg <= '0;
            timer_reg <= '0;
        end else begin
            sent_reg  <= sent_next;
            acked_reg <= acked_next;
            timer_reg <= timer_next;
        end
    end

    assign sent_vec  = sent_reg;
    assign acked_vec = acked_reg;
    assign timer_vec = timer_reg;

endmodule

### sv/srs_seq.sv
`timescale 1ns / 1ps

module srs_seq (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [srs_pkg::S_DATA_W-1:0]                   s_tdata,
    input  logic [srs_pkg::ACT_W-1:0]                      s_tuser,
    input  srs_pkg::cfg_t                                  cfg,
    input  logic [srs_pkg::MAX_WINDOW-1:0]                 sent_vec,
    input  logic [srs_pkg::MAX_WINDOW-1:0]                 acked_vec,
    input  logic [srs_pkg::MAX_WINDOW-1:0][srs_pkg::TMR_W-1:0] timer_vec,
    output srs_pkg::slot_cmd_t                             cmd,
    output logic                                           res_valid,
    output srs_pkg::result_t                               res,
    input  logic                                           res_ready
);
    import srs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_ACK   = 5'b00100,
        ST_SLIDE = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   action_reg, action_next;
    logic [FRAME_W-1:0] ack_reg, ack_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [ATT_W-1:0]   att_reg, att_next;
    logic [FRAME_W-1:0] base_reg, base_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [EV_W-1:0]    pend_ev_reg, pend_ev_next;
    logic [FRAME_W-1:0] pend_frame_reg, pend_frame_next;

    logic [CNT_W-1:0]   win_eff;
    logic [FRAME_W:0]   frame_sum;
    logic [FRAME_W:0]   ack_hi;
    logic [SLOT_W-1:0]  rd_slot;
    logic               rd_sent, rd_acked, rd_expire;
    logic               scan_end, in_win, is_tx, touch, hit, lost;

    // effective window: zero acts as one, capped by slots and result limit
    always_comb begin
        if (cfg.win_len == '0) begin
            win_eff = CNT_W'(1);
        end else if (int'(cfg.win_len) > EFF_MAX) begin
            win_eff = CNT_W'(EFF_MAX);
        end else begin
            win_eff = CNT_W'(cfg.win_len);
        end
    end

    // window adders and compares
    assign frame_sum = {1'b0, base_reg} + (FRAME_W + 1)'(k_reg);
    assign ack_hi    = {1'b0, base_reg} + (FRAME_W + 1)'(win_eff);
    assign scan_end  = (k_reg >= win_eff) || (frame_sum >= {1'b0, cfg.frame_count});
    assign in_win    = (ack_reg >= base_reg) && ({1'b0, ack_reg} < ack_hi)
                       && (ack_reg < cfg.frame_count);

    assign rd_slot   = (state_reg == ST_SCAN) ? frame_sum[SLOT_W-1:0] : base_reg[SLOT_W-1:0];
    assign rd_sent   = sent_vec[rd_slot];
    assign rd_acked  = acked_vec[rd_slot];
    assign rd_expire = timer_vec[rd_slot] < TMR_W'(2);

    assign is_tx = (action_reg == ACT_TX);
    assign touch = is_tx ? (!rd_sent && !rd_acked) : (rd_sent && !rd_acked);
    assign hit   = is_tx ? touch : (touch && rd_expire);
    assign lost  = mask_reg[att_reg];

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        action_next     = action_reg;
        ack_next        = ack_reg;
        mask_next       = mask_reg;
        k_next          = k_reg;
        att_next        = att_reg;
        base_next       = base_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_frame_next = pend_frame_reg;
        cmd.op          = SOP_NONE;
        cmd.slot        = rd_slot;
        cmd.timer       = cfg.timeout_ticks;
        res_valid       = 1'b0;
        res.ev          = pend_ev_reg;
        res.frame       = pend_frame_reg;
        res.base        = base_reg;
        res.last        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    action_next     = s_tuser;
                    ack_next        = s_tdata[FRAME_W-1:0];
                    mask_next       = s_tdata[FRAME_W +: MASK_W];
                    k_next          = '0;
                    att_next        = '0;
                    pend_valid_next = 1'b0;
                    case (s_tuser)
                        ACT_TX, ACT_TICK: state_next = ST_SCAN;
                        ACT_ACK:          state_next = ST_ACK;
                        default:          state_next = ST_FLUSH;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_FLUSH;
                end else if (!(hit && pend_valid_reg && !res_ready)) begin
                    k_next = k_reg + CNT_W'(1);
                    if (hit && pend_valid_reg) begin
                        res_valid = 1'b1;
                    end
                    if (is_tx && touch) begin
                        att_next = att_reg + ATT_W'(1);
                        if (!lost) begin
                            cmd.op = SOP_SEND;
                        end
                    end else if (touch) begin
                        cmd.op = SOP_TICK;
                    end
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        pend_frame_next = frame_sum[FRAME_W-1:0];
                        if (!is_tx) begin
                            pend_ev_next = EV_TIMEOUT;
                        end else if (lost) begin
                            pend_ev_next = EV_LOST;
                        end else begin
                            pend_ev_next = EV_SENT;
                        end
                    end
                end
            end
            ST_ACK: begin
                pend_valid_next = 1'b1;
                pend_frame_next = ack_reg;
                if (in_win) begin
                    cmd.op       = SOP_ACK;
                    cmd.slot     = ack_reg[SLOT_W-1:0];
                    pend_ev_next = EV_ACK_OK;
                    state_next   = ST_SLIDE;
                end else begin
                    pend_ev_next = EV_ACK_IGNORED;
                    state_next   = ST_FLUSH;
                end
            end
            ST_SLIDE: begin
                if ((base_reg < cfg.frame_count) && rd_acked) begin
                    cmd.op    = SOP_CLEAR;
                    base_next = base_reg + FRAME_W'(1);
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                res_valid = 1'b1;
                res.last  = 1'b1;
                if (!pend_valid_reg) begin
                    res.ev    = EV_NONE;
                    res.frame = '0;
                end
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            pend_valid_reg <= 1'b0;
            k_reg          <= '0;
            att_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            pend_valid_reg <= pend_valid_next;
            k_reg          <= k_next;
            att_reg        <= att_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg     <= action_next;
        ack_reg        <= ack_next;
        mask_reg       <= mask_next;
        pend_ev_reg    <= pend_ev_next;
        pend_frame_reg <= pend_frame_next;
    end

endmodule

### sv/srs_checker.sv
`timescale 1ns / 1ps

module srs_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [srs_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic [srs_pkg::EV_W-1:0]        m_tuser,
    input  logic                            m_tlast
);
    import srs_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // none result carries frame zero and ends the transaction group
    a_none_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_NONE) |-> (m_tdata[FRAME_W-1:0] == '0) && m_tlast)
        else $error("malformed none result");

    // ack outcomes are always a single result
    a_ack_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == EV_ACK_OK) || (m_tuser == EV_ACK_IGNORED)) |-> m_tlast)
        else $error("ack result not last");

endmodule

bind selective_repeat_sender_unit srs_checker u_srs_checker (.*);

### tb/selective_repeat_sender_unit_test.sv
`timescale 1ns / 1ps

module selective_repeat_sender_unit_test;
    import srs_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        bit                 cfg;
        logic [1:0]         code;
        logic [FRAME_W-1:0] value;
        logic [MASK_W-1:0]  mask;
        bit                 typed;
        logic [EV_W-1:0]    ev;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] base;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // ack_frame, loss_mask
    logic [ACT_W-1:0]      s_tuser;   // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;   // frame_number, window_base
    logic [EV_W-1:0]       m_tuser;   // event_res
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IX_W-1:0]   cfg_index;
    logic [CFG_D_W-1:0]    cfg_wdata;

    // sender window model
    logic [WIN_W-1:0]   cfg_window;
    logic [FRAME_W-1:0] cfg_frames;
    logic [TMR_W-1:0]   cfg_timeout;
    logic [FRAME_W-1:0] win_base;
    bit                 tx_done [MAX_WINDOW];
    bit                 acked [MAX_WINDOW];
    logic [TMR_W-1:0]   retry_timer [MAX_WINDOW];

    result_t step_events [$];
    result_t pending_events [$];
    result_t rx_got;
    result_t rx_want;
    int      rx_hold;
    bit      tx_quiet;
    bit      rx_quiet;
    int      mismatch_count;

    plan_row_t dir_plan [$] = '{
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b1, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_ACK, 16'd0, 8'h00, 1'b1, EV_ACK_OK, 16'd0, 16'd1},
        '{1'b0, ACT_UNKNOWN, 16'hFFFF, 8'hFF, 1'b1, EV_NONE, 16'd0, 16'd1},
        '{1'b0, ACT_ACK, 16'hFFFF, 8'h00, 1'b1, EV_ACK_IGNORED, 16'hFFFF, 16'd1},
        '{1'b0, ACT_ACK, 16'd0, 8'h00, 1'b1, EV_ACK_IGNORED, 16'd0, 16'd1},
        '{1'b0, ACT_ACK, 16'd5, 8'h00, 1'b1, EV_ACK_IGNORED, 16'd5, 16'd1},
        '{1'b0, ACT_TX, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_ACK, 16'd3, 8'h00, 1'b1, EV_ACK_OK, 16'd3, 16'd1},
        '{1'b0, ACT_ACK, 16'd3, 8'h00, 1'b1, EV_ACK_OK, 16'd3, 16'd1},
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b1, EV_NONE, 16'd0, 16'd1},
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b1, EV_NONE, 16'd0, 16'd1},
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TX, 16'd0, 8'hFF, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TX, 16'd0, 8'h02, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_ACK, 16'd1, 8'h00, 1'b1, EV_ACK_OK, 16'd1, 16'd2},
        '{1'b1, CFG_TIMEOUT_TICKS, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TX, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b1, CFG_WIN_LEN, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TX, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_ACK, 16'd3, 8'h00, 1'b1, EV_ACK_IGNORED, 16'd3, 16'd2},
        '{1'b1, CFG_WIN_LEN, 16'd15, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b1, CFG_FRAME_COUNT, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b1, EV_NONE, 16'd0, 16'd2},
        '{1'b0, ACT_ACK, 16'd2, 8'h00, 1'b1, EV_ACK_IGNORED, 16'd2, 16'd2},
        '{1'b0, ACT_TX, 16'd0, 8'h00, 1'b1, EV_NONE, 16'd0, 16'd2},
        '{1'b1, CFG_FRAME_COUNT, 16'hFFFF, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b1, CFG_TIMEOUT_TICKS, 16'd15, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_TX, 16'd0, 8'hAA, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{1'b0, ACT_ACK, 16'd2, 8'h00, 1'b1, EV_ACK_OK, 16'd2, 16'd4},
        '{1'b0, ACT_TICK, 16'd0, 8'h00, 1'b0, EV_NONE, 16'd0, 16'd0}
    };

    selective_repeat_sender_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count < 200) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    function automatic int unsigned eff_window();
        int unsigned w;
        w = cfg_window;
        if (w < 1) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        if (w > RESULT_LIMIT) w = RESULT_LIMIT;
        return w;
    endfunction

    function automatic void add_event(input logic [EV_W-1:0] ev, input int unsigned frame);
        step_events.push_back('{ev, 16'(frame), win_base, 1'b0});
    endfunction

    function automatic void arq_events(input logic [ACT_W-1:0] act,
                                       input logic [FRAME_W-1:0] ack,
                                       input logic [MASK_W-1:0] mask);
        int unsigned w;
        int unsigned f;
        int unsigned k;
        int unsigned attempt;
        int unsigned s;
        step_events.delete();
        w = eff_window();
        attempt = 0;
        case (act)
            ACT_TX: begin
                for (k = 0; k < w; k++) begin
                    f = win_base + k;
                    if (f >= cfg_frames) break;
                    s = f % MAX_WINDOW;
                    if (tx_done[s] || acked[s]) continue;
                    if (mask[attempt & 7]) begin
                        add_event(EV_LOST, f);
                    end else begin
                        tx_done[s] = 1'b1;
                        retry_timer[s] = cfg_timeout;
                        add_event(EV_SENT, f);
                    end
                    attempt++;
                end
            end
            ACT_ACK: begin
                if (ack >= win_base && ack < win_base + w && ack < cfg_frames) begin
                    s = ack % MAX_WINDOW;
                    acked[s] = 1'b1;
                    retry_timer[s] = '0;
                    while (win_base < cfg_frames && acked[win_base % MAX_WINDOW]) begin
                        s = win_base % MAX_WINDOW;
                        acked[s] = 1'b0;
                        tx_done[s] = 1'b0;
                        retry_timer[s] = '0;
                        win_base = win_base + 16'd1;
                    end
                    add_event(EV_ACK_OK, ack);
                end else begin
                    add_event(EV_ACK_IGNORED, ack);
                end
            end
            ACT_TICK: begin
                for (k = 0; k < w; k++) begin
                    f = win_base + k;
                    if (f >= cfg_frames) break;
                    s = f % MAX_WINDOW;
                    if (tx_done[s] && !acked[s]) begin
                        if (retry_timer[s] > 0) retry_timer[s] = retry_timer[s] - 4'd1;
                        if (retry_timer[s] == 0) begin
                            tx_done[s] = 1'b0;
                            add_event(EV_TIMEOUT, f);
                        end
                    end
                end
            end
            default: ;
        endcase
        if (step_events.size() == 0) add_event(EV_NONE, 0);
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [FRAME_W-1:0] ack,
                             input logic [MASK_W-1:0] mask, input bit typed,
                             input logic [EV_W-1:0] ev, input logic [FRAME_W-1:0] frame,
                             input logic [FRAME_W-1:0] base);
        int gap;
        result_t r;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        cfg_we <= 1'b0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {mask, ack};
        do @(posedge aclk); while (!s_tready);
        arq_events(act, ack, mask);
        if (typed) begin
            pending_events.push_back('{ev, frame, base, 1'b1});
        end else begin
            foreach (step_events[i]) begin
                r = step_events[i];
                r.last = (i == step_events.size() - 1);
                pending_events.push_back(r);
            end
        end
    endtask

    // register writes only once every outstanding result has drained
    task automatic write_cfg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] value);
        s_tvalid <= 1'b0;
        cfg_we <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_WIN_LEN:       cfg_window = value[WIN_W-1:0];
            CFG_FRAME_COUNT:   cfg_frames = value;
            CFG_TIMEOUT_TICKS: cfg_timeout = value[TMR_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end else if (m_tvalid && m_tready) begin
            rx_got = '{m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast};
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("unexpected result: event %0d frame %0d base %0d",
                                          rx_got.ev, rx_got.frame, rx_got.base));
            end else begin
                rx_want = pending_events.pop_front();
                if (rx_got.ev != rx_want.ev)
                    report_mismatch($sformatf("event %0d, expected %0d (frame %0d)",
                                              rx_got.ev, rx_want.ev, rx_want.frame));
                if (rx_got.frame != rx_want.frame)
                    report_mismatch($sformatf("frame_number %0d, expected %0d",
                                              rx_got.frame, rx_want.frame));
                if (rx_got.base != rx_want.base)
                    report_mismatch($sformatf("window_base %0d, expected %0d (frame %0d)",
                                              rx_got.base, rx_want.base, rx_want.frame));
                if (rx_got.last != rx_want.last)
                    report_mismatch($sformatf("tlast %0b, expected %0b (frame %0d)",
                                              rx_got.last, rx_want.last, rx_want.frame));
            end
            rx_hold = rx_quiet ? 0 : $urandom_range(0, 6);
            if (rx_hold != 0) m_tready <= 1'b0;
        end else if (!m_tready) begin
            if (rx_hold > 0) rx_hold--;
            if (rx_hold == 0) m_tready <= 1'b1;
        end
    end

    initial begin
        int unsigned r;
        int unsigned w;
        logic [ACT_W-1:0] act;
        logic [FRAME_W-1:0] ack;
        logic [MASK_W-1:0] mask;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        mismatch_count = 0;
        cfg_window = RST_WIN_LEN;
        cfg_frames = RST_FRAME_COUNT;
        cfg_timeout = RST_TIMEOUT_TICKS;
        win_base = '0;
        foreach (tx_done[i]) begin
            tx_done[i] = 1'b0;
            acked[i] = 1'b0;
            retry_timer[i] = '0;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_plan[i]) begin
            if (dir_plan[i].cfg)
                write_cfg(dir_plan[i].code, dir_plan[i].value);
            else
                send_item(dir_plan[i].code, dir_plan[i].value, dir_plan[i].mask,
                          dir_plan[i].typed, dir_plan[i].ev, dir_plan[i].frame,
                          dir_plan[i].base);
        end

        for (int ph = 0; ph < 6; ph++) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            write_cfg(CFG_WIN_LEN, 16'($urandom_range(0, 15)));
            if ($urandom_range(0, 6) == 0)
                write_cfg(CFG_FRAME_COUNT, 16'($urandom));
            else
                write_cfg(CFG_FRAME_COUNT, 16'(win_base + $urandom_range(0, 40)));
            if ($urandom_range(0, 3) != 0)
                write_cfg(CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 4)));
            else
                write_cfg(CFG_TIMEOUT_TICKS, 16'($urandom_range(0, 15)));

            for (int n = 0; n < 30; n++) begin
                r = $urandom_range(0, 99);
                if (r < 35) act = ACT_TX;
                else if (r < 75) act = ACT_ACK;
                else if (r < 95) act = ACT_TICK;
                else act = ACT_UNKNOWN;

                // mostly in-window acks, some at the edges and some anywhere
                w = eff_window();
                r = $urandom_range(0, 99);
                if (r < 70) ack = 16'(win_base + $urandom_range(0, w - 1));
                else if (r < 80) ack = 16'(win_base + w);
                else if (r < 88) ack = win_base - 16'd1;
                else ack = 16'($urandom);

                if ($urandom_range(0, 1) != 0) mask = 8'($urandom & $urandom & $urandom);
                else mask = 8'($urandom);

                send_item(act, ack, mask, 1'b0, EV_NONE, 16'd0, 16'd0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
